// ===== sv/brf_pkg.sv =====
// Shared types and constants for the byte ring FIFO burst core.
// No dependencies; compiled first.
package brf_pkg;

	// Default geometry
	localparam int DEPTH_DEF = 4096;
	localparam int LANES_DEF = 8;

	// Fixed field widths of the request and response words
	localparam int KIND_W = 3;
	localparam int LEN_W  = 13;
	localparam int DATA_W = 64;
	localparam int BYTES  = DATA_W / 8;
	localparam int LW     = $clog2(BYTES);

	// Operation codes
	typedef enum logic [KIND_W-1:0] {
		KIND_PUT_PART  = 3'd0,
		KIND_PUT_EXACT = 3'd1,
		KIND_GET_PART  = 3'd2,
		KIND_GET_EXACT = 3'd3,
		KIND_PEEK_PART = 3'd4,
		KIND_PEEK_EXACT = 3'd5,
		KIND_COMMIT    = 3'd6,
		KIND_NOP       = 3'd7
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [LEN_W-1:0]  length;
		logic [DATA_W-1:0] data_bytes;
	} req_t;

	typedef struct packed {
		logic [LEN_W-1:0]  granted;
		logic [DATA_W-1:0] read_bytes;
		logic [LEN_W-1:0]  fill_level;
	} rsp_t;

endpackage

// ===== sv/brf_if.sv =====
// Valid/ready channel carrying one word of a payload type.
// Used with brf_pkg::req_t and brf_pkg::rsp_t.
interface brf_if #(parameter type item_t = logic);
	logic  valid;
	logic  ready;
	item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/brf_bank.sv =====
// One byte-wide bank of the ring store: one write port, one registered read port.
// Depends on nothing; instantiated once per bank by the core.
module brf_bank #(
	parameter int RW = 9
) (
	input  logic          clk,
	input  logic          we,
	input  logic [RW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [RW-1:0] raddr,
	output logic [7:0]    rdata_q
);

	logic [7:0] mem [2**RW];

	// Write one byte
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read one byte, hold it until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

// ===== sv/brf_merge.sv =====
// Merge stage: rotates the bank outputs back into byte order and masks
// bytes beyond the grant. Depends on brf_pkg.
module brf_merge
	import brf_pkg::*;
#(
	parameter int LANES = LANES_DEF,
	parameter int BANKS = 8,
	parameter int BSW   = 3
) (
	input  logic [2**BSW-1:0][7:0] bank_q,
	input  logic [LW-1:0]          rot,
	input  logic [LEN_W-1:0]       grant,
	input  logic                   is_read,
	output logic [DATA_W-1:0]      read_bytes
);

	// Pick the bank that holds each output byte
	always_comb begin
		logic [BSW-1:0] sel;
		read_bytes = '0;
		for (int i = 0; i < BYTES; i++) begin
			sel = BSW'((LW+1)'(rot) + (LW+1)'(i)) & BSW'(BANKS - 1);
			if (is_read && (i < LANES) && (LEN_W'(i) < grant)) begin
				read_bytes[i*8 +: 8] = bank_q[sel];
			end
		end
	end

endmodule

// ===== sv/byte_ring_fifo_burst_core.sv =====
// Byte ring FIFO burst core: top level. Depends on brf_pkg, brf_if,
// brf_bank and brf_merge.
//
// A request word (put, get, peek, commit) is accepted every clock cycle as
// long as the response side keeps taking words; the response is presented in
// the cycle after acceptance, from the registered read of the byte banks. The
// DEPTH-byte ring is split over a power-of-two number of byte banks, at
// least LANES, so that the up to LANES consecutive bytes of one burst land
// in distinct banks and are all written or read in the same cycle. Read and
// write pointers run modulo 2*DEPTH; the fill level is their difference.
// Storage needs no clearing after reset, so a request is taken from the
// first cycle. A stalled response holds the request side.
module byte_ring_fifo_burst_core
	import brf_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int LANES = LANES_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	brf_if.sink   req,
	brf_if.source rsp
);

	localparam int IW    = $clog2(DEPTH);
	localparam int PW    = IW + 1;
	localparam int CW    = (PW > LEN_W) ? PW : LEN_W;
	localparam int BB    = $clog2(LANES);
	localparam int BANKS = 1 << BB;
	localparam int BSW   = (BB > 0) ? BB : 1;
	localparam int RW    = IW - BB;

	logic [PW-1:0]    wp_q, rp_q;
	logic             v_s1, rd_s1;
	logic [LEN_W-1:0] grant_s1, fill_s1;
	logic [LW-1:0]    rot_s1;

	logic             acc;
	kind_t            kind;
	logic [LEN_W-1:0] len;
	logic [PW-1:0]    used, space;
	logic [LW:0]      dlen, dgr;
	logic [LEN_W-1:0] grant_nx, fill_nx;
	logic [PW-1:0]    wp_nx, rp_nx;
	logic             is_put, is_read, is_get, is_peek;
	logic [2**BSW-1:0][7:0] bank_q;

	assign req.ready = !v_s1 || rsp.ready;
	assign acc       = req.valid && req.ready;
	assign kind      = req.payload.kind;
	assign len       = req.payload.length;

	assign is_put  = (kind == KIND_PUT_PART) || (kind == KIND_PUT_EXACT);
	assign is_get  = (kind == KIND_GET_PART) || (kind == KIND_GET_EXACT);
	assign is_peek = (kind == KIND_PEEK_PART) || (kind == KIND_PEEK_EXACT);
	assign is_read = is_get || is_peek;

	// Fill level, free space and the clamped burst length
	assign used  = wp_q - rp_q;
	assign space = PW'(DEPTH) - used;
	assign dlen  = (len > LEN_W'(LANES)) ? (LW+1)'(LANES) : len[LW:0];

	// Grant per operation
	always_comb begin
		dgr      = '0;
		grant_nx = '0;
		case (kind)
			KIND_PUT_PART: begin
				dgr = (CW'(space) < CW'(dlen)) ? (LW+1)'(space) : dlen;
			end
			KIND_PUT_EXACT: begin
				dgr = (CW'(dlen) <= CW'(space)) ? dlen : '0;
			end
			KIND_GET_PART, KIND_PEEK_PART: begin
				dgr = (CW'(used) < CW'(dlen)) ? (LW+1)'(used) : dlen;
			end
			KIND_GET_EXACT, KIND_PEEK_EXACT: begin
				dgr = (CW'(dlen) <= CW'(used)) ? dlen : '0;
			end
			KIND_COMMIT: begin
				grant_nx = (CW'(len) > CW'(used)) ? LEN_W'(used) : len;
			end
			default: begin
				dgr = '0;
			end
		endcase
		if (kind != KIND_COMMIT) begin
			grant_nx = LEN_W'(dgr);
		end
	end

	// Advance the pointers
	assign wp_nx   = is_put ? (wp_q + PW'(dgr)) : wp_q;
	assign rp_nx   = (is_get || (kind == KIND_COMMIT)) ? (rp_q + PW'(grant_nx)) : rp_q;
	assign fill_nx = LEN_W'(wp_nx - rp_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			if (acc) begin
				wp_q <= wp_nx;
				rp_q <= rp_nx;
			end
			if (req.ready) begin
				v_s1 <= req.valid;
			end
		end
	end

	// Response stage payload
	always_ff @(posedge clk) begin
		if (acc) begin
			grant_s1 <= grant_nx;
			fill_s1  <= fill_nx;
			rot_s1   <= LW'(rp_q) & LW'(BANKS - 1);
			rd_s1    <= is_read;
		end
	end

	// Byte banks: bank b holds ring addresses with b in the low bits
	for (genvar b = 0; b < 2**BSW; b++) begin : g_bank
		if (b < BANKS) begin : g_live
			logic [IW-1:0] woff, roff, wa, ra;
			logic          we;

			assign woff = (IW'(b) - wp_q[IW-1:0]) & IW'(BANKS - 1);
			assign roff = (IW'(b) - rp_q[IW-1:0]) & IW'(BANKS - 1);
			assign wa   = wp_q[IW-1:0] + woff;
			assign ra   = rp_q[IW-1:0] + roff;
			assign we   = acc && is_put && ((LW+1)'(woff) < dgr);

			brf_bank #(.RW(RW)) u_bank (
				.clk     (clk),
				.we      (we),
				.waddr   (wa[IW-1:BB]),
				.wdata   (req.payload.data_bytes[LW'(woff)*8 +: 8]),
				.re      (acc && is_read),
				.raddr   (ra[IW-1:BB]),
				.rdata_q (bank_q[b])
			);
		end else begin : g_pad
			assign bank_q[b] = '0;
		end
	end

	// Merge the bank bytes into the response word
	brf_merge #(.LANES(LANES), .BANKS(BANKS), .BSW(BSW)) u_merge (
		.bank_q     (bank_q),
		.rot        (rot_s1),
		.grant      (grant_s1),
		.is_read    (rd_s1),
		.read_bytes (rsp.payload.read_bytes)
	);

	assign rsp.valid              = v_s1;
	assign rsp.payload.granted    = grant_s1;
	assign rsp.payload.fill_level = fill_s1;

	// The ring never holds more than its depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(wp_q - rp_q) <= PW'(DEPTH))
		else $error("fill exceeds depth");

	// A pending response reports the fill left by the pointers
	a_fill_match: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (fill_s1 == LEN_W'(wp_q - rp_q)))
		else $error("reported fill disagrees with pointers");

	// Peek leaves the read pointer in place
	a_peek_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_peek) |=> $stable(rp_q))
		else $error("peek moved the read pointer");

	// A read burst never grants more than the lane count
	a_read_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && rd_s1) |-> (grant_s1 <= LEN_W'(LANES)))
		else $error("read grant above lane count");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for byte_ring_fifo_burst_core: random and directed
// put/get/peek/commit words checked against an in-bench ring model.
// Depends on brf_pkg, brf_if and byte_ring_fifo_burst_core.
module tb;
	import brf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int LANES       = LANES_DEF;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int PTR_W       = $clog2(DEPTH) + 1;
	localparam int PHASE_ITEMS = 95;
	localparam int STALL_LIMIT = 5000;
	localparam int MAX_SHOWN   = 10;

	typedef enum {GEN_FILL, GEN_HIGH, GEN_DRAIN, GEN_LOW} gen_mode_t;

	logic clk;
	logic arst_n;

	brf_if #(.item_t(req_t)) req_ch ();
	brf_if #(.item_t(rsp_t)) rsp_ch ();

	byte_ring_fifo_burst_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Ring model state
	logic [7:0]       ring_copy [DEPTH];
	logic [PTR_W-1:0] wr_ptr;
	logic [PTR_W-1:0] rd_ptr;

	req_t req_pending [$];
	rsp_t rsp_due [$];
	logic req_taken;
	int   n_issued;
	int   n_taken;
	int   err_count;
	int   src_idle_pct;
	int   sink_stall_pct;
	int   quiet_cycles;

	function automatic int ring_fill();
		logic [PTR_W-1:0] diff;
		diff = wr_ptr - rd_ptr;
		return int'(diff);
	endfunction

	// Apply one request word to the ring model and return the response it causes
	function automatic rsp_t ring_apply(req_t r);
		rsp_t res;
		int   used;
		int   dlen;
		int   grant;
		int   i;
		used  = ring_fill();
		dlen  = (r.length > LANES) ? LANES : int'(r.length);
		grant = 0;
		res   = '0;
		case (r.kind)
			KIND_PUT_PART, KIND_PUT_EXACT: begin
				if (r.kind == KIND_PUT_PART)
					grant = (dlen < DEPTH - used) ? dlen : DEPTH - used;
				else
					grant = (dlen <= DEPTH - used) ? dlen : 0;
				for (i = 0; i < grant; i++)
					ring_copy[IDX_W'(wr_ptr + PTR_W'(i))] = r.data_bytes[8*i +: 8];
				wr_ptr = wr_ptr + PTR_W'(grant);
			end
			KIND_GET_PART, KIND_GET_EXACT, KIND_PEEK_PART, KIND_PEEK_EXACT: begin
				if (r.kind == KIND_GET_PART || r.kind == KIND_PEEK_PART)
					grant = (dlen < used) ? dlen : used;
				else
					grant = (dlen <= used) ? dlen : 0;
				for (i = 0; i < grant; i++)
					res.read_bytes[8*i +: 8] = ring_copy[IDX_W'(rd_ptr + PTR_W'(i))];
				if (r.kind == KIND_GET_PART || r.kind == KIND_GET_EXACT)
					rd_ptr = rd_ptr + PTR_W'(grant);
			end
			KIND_COMMIT: begin
				grant  = (int'(r.length) < used) ? int'(r.length) : used;
				rd_ptr = rd_ptr + PTR_W'(grant);
			end
			default: begin
				grant = 0;
			end
		endcase
		res.granted    = LEN_W'(grant);
		res.fill_level = LEN_W'(ring_fill());
		return res;
	endfunction

	task automatic note_error(string msg);
		err_count++;
		if (err_count <= MAX_SHOWN)
			$display("[%0t] %s", $realtime, msg);
	endtask

	task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
		if (want !== got)
			note_error($sformatf("%s mismatch: expected %h, got %h", name, want, got));
	endtask

	// Queue one request word, keeping at most two waiting for the driver
	task automatic queue_req(kind_t k, int len, logic [DATA_W-1:0] d);
		req_t r;
		r.kind       = k;
		r.length     = LEN_W'(len);
		r.data_bytes = d;
		while (req_pending.size() >= 2)
			@(negedge clk);
		req_pending.push_back(r);
		n_issued++;
	endtask

	// Queue one random word: puts at put_pct percent, else commits, reads, rare no-ops
	task automatic queue_random(int put_pct, int commit_max);
		int    roll;
		int    len;
		kind_t k;
		roll = $urandom_range(0, 99);
		if (roll < put_pct) begin
			k   = ($urandom_range(0, 1) != 0) ? KIND_PUT_EXACT : KIND_PUT_PART;
			len = ($urandom_range(0, 6) != 0) ? $urandom_range(LANES, 4096)
			                                  : $urandom_range(0, LANES);
		end else if (roll == 99) begin
			k   = KIND_NOP;
			len = $urandom_range(0, 4096);
		end else if ($urandom_range(0, 2) == 0) begin
			k   = KIND_COMMIT;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4096)
			                                  : $urandom_range(0, commit_max);
		end else begin
			k   = kind_t'($urandom_range(KIND_GET_PART, KIND_PEEK_EXACT));
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4096)
			                                  : $urandom_range(0, LANES);
		end
		queue_req(k, len, {$urandom, $urandom});
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Driver: hold a word until taken, then offer the next or idle
	always @(negedge clk) begin
		if (arst_n && (!req_ch.valid || req_taken)) begin
			if (req_pending.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
				req_ch.payload <= req_pending.pop_front();
				req_ch.valid   <= 1'b1;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Response side: stall at random
	always @(negedge clk) begin
		if (arst_n)
			rsp_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// Monitor: predict on each accepted request, check each accepted response
	always @(posedge clk) begin : monitor
		rsp_t want;
		if (arst_n) begin
			req_taken <= req_ch.valid && req_ch.ready;
			if (req_ch.valid && req_ch.ready) begin
				rsp_due.push_back(ring_apply(req_ch.payload));
				n_taken++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (rsp_due.size() == 0) begin
					note_error($sformatf("response with nothing outstanding: %h",
						rsp_ch.payload));
				end else begin
					want = rsp_due.pop_front();
					check_field("granted", DATA_W'(want.granted),
						DATA_W'(rsp_ch.payload.granted));
					check_field("read_bytes", want.read_bytes, rsp_ch.payload.read_bytes);
					check_field("fill_level", DATA_W'(want.fill_level),
						DATA_W'(rsp_ch.payload.fill_level));
				end
			end
		end
	end

	// Watchdog: end the run when no word moves for too long
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no word accepted for %0d cycles", quiet_cycles);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus and end of run
	initial begin : stimulus
		gen_mode_t gen_mode;
		int        dwell;
		int        phase;
		int        n;
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.payload = '0;
		rsp_ch.ready   = 1'b0;
		req_taken      = 1'b0;
		n_issued       = 0;
		n_taken        = 0;
		err_count      = 0;
		quiet_cycles   = 0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		wr_ptr         = '0;
		rd_ptr         = '0;
		gen_mode       = GEN_FILL;
		dwell          = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty FIFO: reads and commits grant nothing; no-op with busy fields
		queue_req(KIND_GET_PART, LANES, '1);
		queue_req(KIND_GET_EXACT, LANES, '0);
		queue_req(KIND_PEEK_PART, 4096, '1);
		queue_req(KIND_PEEK_EXACT, 1, '0);
		queue_req(KIND_COMMIT, 4096, '1);
		queue_req(KIND_NOP, 4096, '1);
		// Puts: zero length, short, full lane, clamped length
		queue_req(KIND_PUT_PART, 0, '1);
		queue_req(KIND_PUT_PART, 3, 64'h0123_4567_89AB_CDEF);
		queue_req(KIND_PUT_EXACT, LANES, '1);
		queue_req(KIND_PUT_EXACT, 4096, 64'hFEDC_BA98_7654_3210);
		queue_req(KIND_PUT_PART, 5, '0);
		// Reads with clamped lengths, then exact refusal when short
		queue_req(KIND_PEEK_EXACT, LANES, '0);
		queue_req(KIND_PEEK_PART, 4096, '0);
		queue_req(KIND_GET_EXACT, 100, '0);
		queue_req(KIND_GET_PART, 1, '0);
		queue_req(KIND_GET_EXACT, 16, '0);
		queue_req(KIND_GET_EXACT, LANES, '0);
		queue_req(KIND_PEEK_EXACT, LANES, '0);
		queue_req(KIND_PEEK_PART, LANES, '0);
		queue_req(KIND_GET_PART, LANES, '0);
		// Commit within and beyond the used count
		queue_req(KIND_PUT_EXACT, LANES, {$urandom, $urandom});
		queue_req(KIND_COMMIT, 3, '0);
		queue_req(KIND_COMMIT, 4096, '0);

		// Random words over the idling phases; steer fill between empty and full
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 70; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 70; end
				default: begin src_idle_pct = 6; sink_stall_pct = 6; end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				case (gen_mode)
					GEN_FILL: begin
						queue_random(95, 16);
						if (ring_fill() >= DEPTH - LANES) begin
							gen_mode = GEN_HIGH;
							dwell    = 24;
						end
					end
					GEN_HIGH: begin
						queue_random(50, 12);
						dwell--;
						if (dwell == 0)
							gen_mode = GEN_DRAIN;
					end
					GEN_DRAIN: begin
						queue_random(15, 600);
						if (ring_fill() <= LANES) begin
							gen_mode = GEN_LOW;
							dwell    = 24;
						end
					end
					default: begin
						queue_random(50, 12);
						dwell--;
						if (dwell == 0)
							gen_mode = GEN_FILL;
					end
				endcase
			end
		end

		// Drain: wait for every word to be taken and answered, then settle
		while (n_taken != n_issued || rsp_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (rsp_due.size() != 0)
			note_error($sformatf("%0d responses never arrived", rsp_due.size()));

		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/brf_pkg.sv
sv/brf_if.sv
sv/brf_bank.sv
sv/brf_merge.sv
sv/byte_ring_fifo_burst_core.sv
tb/tb.sv
